// ===== rtl/tpsc_pkg.sv =====
package tpsc_pkg;

    localparam int RAW_W     = 16;                // raw samples and raw calibration points
    localparam int OUT_W     = 16;                // calibrated values
    localparam int TREF_W    = 10;                // temperature reference points
    localparam int HREF_W    = 8;                 // humidity reference points
    localparam int TEMP_MULT = 25;
    localparam int HUM_MULT  = 50;
    localparam int NUM_W     = 33;                // signed numerator of the line division
    localparam int MAG_W     = NUM_W - 1;         // numerator magnitude, one quotient bit per step
    localparam int CNT_W     = $clog2(MAG_W);
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    localparam logic [1:0] READY_MASK = 2'b11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_RAW_LOW  = 4'd0,
        REG_TEMP_RAW_HIGH = 4'd1,
        REG_TEMP_REF_LOW  = 4'd2,
        REG_TEMP_REF_HIGH = 4'd3,
        REG_HUM_RAW_LOW   = 4'd4,
        REG_HUM_RAW_HIGH  = 4'd5,
        REG_HUM_REF_LOW   = 4'd6,
        REG_HUM_REF_HIGH  = 4'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_MUL,
        LS_SCALE,
        LS_PREP,
        LS_DIV,
        LS_FIN,
        LS_DONE
    } lane_state_t;

    // what one lane hands to the merging stage
    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] value;
    } lane_result_t;

endpackage

// ===== rtl/tpsc_lane.sv =====
module tpsc_lane #(
    parameter int Y_W  = tpsc_pkg::TREF_W,
    parameter int MULT = tpsc_pkg::TEMP_MULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              ack,
    input  logic signed [tpsc_pkg::RAW_W-1:0] raw_low,
    input  logic signed [tpsc_pkg::RAW_W-1:0] raw_high,
    input  logic        [Y_W-1:0]             ref_low,
    input  logic        [Y_W-1:0]             ref_high,
    input  logic signed [tpsc_pkg::RAW_W-1:0] sample,
    output tpsc_pkg::lane_result_t            result
);
    import tpsc_pkg::*;

    localparam int DY_W   = Y_W + 1;
    localparam int PROD_W = RAW_W + 1 + DY_W;
    localparam logic signed [NUM_W-1:0] MULT_C   = NUM_W'(MULT);
    localparam logic        [OUT_W-1:0] MULT_OUT = OUT_W'(MULT);
    localparam logic        [CNT_W-1:0] LAST_CNT = CNT_W'(MAG_W - 1);

    lane_state_t state_reg, state_next;

    logic signed [RAW_W:0]    dx_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic        [MAG_W-1:0]  dividend_reg;
    logic        [RAW_W:0]    den_reg;
    logic        [RAW_W:0]    rem_reg;
    logic        [OUT_W-1:0]  quot_reg;
    logic                     neg_reg;
    logic                     zero_reg;
    logic        [CNT_W-1:0]  cnt_reg;
    logic        [OUT_W-1:0]  value_reg;

    logic signed [RAW_W:0]  d;
    logic signed [RAW_W:0]  d_bias;
    logic signed [RAW_W:0]  half_d;
    logic signed [DY_W-1:0] dy;
    logic        [RAW_W+1:0] trial;
    logic        [RAW_W+1:0] diff;
    logic                    take;
    logic        [OUT_W-1:0] q_signed;

    // span of the raw points at full width, halved toward zero for rounding
    assign d      = {raw_high[RAW_W-1], raw_high} - {raw_low[RAW_W-1], raw_low};
    assign d_bias = d + {{RAW_W{1'b0}}, d[RAW_W]};
    assign half_d = d_bias >>> 1;
    assign dy     = $signed({1'b0, ref_high}) - $signed({1'b0, ref_low});

    // one restoring step: bring down the next numerator bit
    assign trial    = {rem_reg, dividend_reg[MAG_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign take     = trial >= {1'b0, den_reg};
    assign q_signed = neg_reg ? (~quot_reg + OUT_W'(1)) : quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        result.done  = 1'b0;
        result.value = value_reg;
        case (state_reg)
            LS_IDLE:  if (start) state_next = LS_MUL;
            LS_MUL:   state_next = LS_SCALE;
            LS_SCALE: state_next = LS_PREP;
            LS_PREP:  state_next = LS_DIV;
            LS_DIV:   if (cnt_reg == LAST_CNT) state_next = LS_FIN;
            LS_FIN:   state_next = LS_DONE;
            LS_DONE:
            begin
                result.done = 1'b1;
                if (ack) state_next = LS_IDLE;
            end
            default:  state_next = LS_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            LS_IDLE:
            begin
                if (start)
                begin
                    dx_reg <= {sample[RAW_W-1], sample} - {raw_low[RAW_W-1], raw_low};
                end
            end
            LS_MUL:
            begin
                prod_reg <= dx_reg * dy;
            end
            LS_SCALE:
            begin
                num_reg <= NUM_W'(prod_reg) * MULT_C + NUM_W'(half_d);
            end
            LS_PREP:
            begin
                dividend_reg <= num_reg[NUM_W-1] ? MAG_W'(-num_reg) : num_reg[MAG_W-1:0];
                den_reg      <= d[RAW_W] ? -d : d;
                neg_reg      <= num_reg[NUM_W-1] ^ d[RAW_W];
                zero_reg     <= (d == '0);
                rem_reg      <= '0;
                quot_reg     <= '0;
                cnt_reg      <= '0;
            end
            LS_DIV:
            begin
                rem_reg      <= take ? diff[RAW_W:0] : trial[RAW_W:0];
                dividend_reg <= {dividend_reg[MAG_W-2:0], 1'b0};
                quot_reg     <= {quot_reg[OUT_W-2:0], take};
                cnt_reg      <= cnt_reg + CNT_W'(1);
            end
            LS_FIN:
            begin
                // only the low bits of the quotient survive the wrap
                value_reg <= zero_reg ? '0 : q_signed + OUT_W'(ref_low) * MULT_OUT;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/tpsc_merge.sv =====
module tpsc_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tpsc_pkg::lane_result_t             temp_res,
    input  tpsc_pkg::lane_result_t             hum_res,
    output logic                               ack,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [tpsc_pkg::OUT_W-1:0]  temperature,
    output logic signed [tpsc_pkg::OUT_W-1:0]  humidity,
    output logic                               temp_changed,
    output logic                               hum_changed
);
    import tpsc_pkg::*;

    logic [OUT_W-1:0] last_temp_reg;
    logic [OUT_W-1:0] last_hum_reg;
    logic             valid_reg;
    logic [OUT_W-1:0] temp_out_reg;
    logic [OUT_W-1:0] hum_out_reg;
    logic             tc_reg;
    logic             hc_reg;

    logic [OUT_W-1:0] t_bias;
    logic [OUT_W-1:0] t_half;
    logic             tc;
    logic             hc;

    // halve the temperature toward zero
    assign t_bias = temp_res.value + {{(OUT_W-1){1'b0}}, temp_res.value[OUT_W-1]};
    assign t_half = {t_bias[OUT_W-1], t_bias[OUT_W-1:1]};
    assign tc     = t_half != last_temp_reg;
    assign hc     = hum_res.value != last_hum_reg;

    // both lanes run in lock step; take them once the output register is free
    assign ack = temp_res.done && hum_res.done && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            last_temp_reg <= '0;
            last_hum_reg  <= '0;
        end
        else
        begin
            if (ack && (tc || hc))
            begin
                valid_reg     <= 1'b1;
                last_temp_reg <= t_half;
                last_hum_reg  <= hum_res.value;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ack && (tc || hc))
        begin
            temp_out_reg <= t_half;
            hum_out_reg  <= hum_res.value;
            tc_reg       <= tc;
            hc_reg       <= hc;
        end
    end

    assign out_valid    = valid_reg;
    assign temperature  = temp_out_reg;
    assign humidity     = hum_out_reg;
    assign temp_changed = tc_reg;
    assign hum_changed  = hc_reg;

endmodule

// ===== rtl/two_point_sensor_calibration.sv =====
// Channel   Handshake               Payload
// --------  ----------------------  ------------------------------------------------
// input     in_valid / in_ready     temp_ready, hum_ready, fetch_ok,
//                                   raw_temperature, raw_humidity
// output    out_valid / out_ready   temperature, humidity, temp_changed, hum_changed
// config    cfg_valid / cfg_ready   cfg_index, cfg_data (cfg_ready always high)
//
// A valid poll goes from acceptance to the result register through the
// multiply, scale and prepare states in each lane, 32 restoring divide steps
// (one quotient bit per cycle), a finishing state and the merge. No new poll
// is taken until the merge has taken the lane results; the serial divider sets
// the rate. A poll without both ready bits or with a failed fetch is accepted
// and dropped at once. Reset clears the calibration points and the stored
// previous values. A result waiting on out_ready does not stop the next poll;
// only a lane result that cannot enter the occupied output register holds the
// lanes and in_ready.
module two_point_sensor_calibration (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  temp_ready,
    input  logic                                  hum_ready,
    input  logic                                  fetch_ok,
    input  logic signed [tpsc_pkg::RAW_W-1:0]     raw_temperature,
    input  logic signed [tpsc_pkg::RAW_W-1:0]     raw_humidity,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [tpsc_pkg::OUT_W-1:0]     temperature,
    output logic signed [tpsc_pkg::OUT_W-1:0]     humidity,
    output logic                                  temp_changed,
    output logic                                  hum_changed,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [tpsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [tpsc_pkg::CFG_DAT_W-1:0] cfg_data
);
    import tpsc_pkg::*;

    // calibration points
    logic signed [RAW_W-1:0] temp_raw_low_reg;
    logic signed [RAW_W-1:0] temp_raw_high_reg;
    logic        [TREF_W-1:0] temp_ref_low_reg;
    logic        [TREF_W-1:0] temp_ref_high_reg;
    logic signed [RAW_W-1:0] hum_raw_low_reg;
    logic signed [RAW_W-1:0] hum_raw_high_reg;
    logic        [HREF_W-1:0] hum_ref_low_reg;
    logic        [HREF_W-1:0] hum_ref_high_reg;

    logic         busy_reg;
    logic         start;
    logic         ack;
    lane_result_t temp_res;
    lane_result_t hum_res;

    // configuration must be written only while idle (left to the user), so always take it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_raw_low_reg  <= '0;
            temp_raw_high_reg <= '0;
            temp_ref_low_reg  <= '0;
            temp_ref_high_reg <= '0;
            hum_raw_low_reg   <= '0;
            hum_raw_high_reg  <= '0;
            hum_ref_low_reg   <= '0;
            hum_ref_high_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TEMP_RAW_LOW:  temp_raw_low_reg  <= cfg_data[RAW_W-1:0];
                REG_TEMP_RAW_HIGH: temp_raw_high_reg <= cfg_data[RAW_W-1:0];
                REG_TEMP_REF_LOW:  temp_ref_low_reg  <= cfg_data[TREF_W-1:0];
                REG_TEMP_REF_HIGH: temp_ref_high_reg <= cfg_data[TREF_W-1:0];
                REG_HUM_RAW_LOW:   hum_raw_low_reg   <= cfg_data[RAW_W-1:0];
                REG_HUM_RAW_HIGH:  hum_raw_high_reg  <= cfg_data[RAW_W-1:0];
                REG_HUM_REF_LOW:   hum_ref_low_reg   <= cfg_data[HREF_W-1:0];
                REG_HUM_REF_HIGH:  hum_ref_high_reg  <= cfg_data[HREF_W-1:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // launch both lanes only on a complete, successful poll
    assign in_ready = !busy_reg;
    assign start    = in_valid && in_ready && fetch_ok
                      && ({hum_ready, temp_ready} == READY_MASK);

    // busy from launch until the merge takes the lane results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (ack)
        begin
            busy_reg <= 1'b0;
        end
    end

    tpsc_lane #(
        .Y_W  (TREF_W),
        .MULT (TEMP_MULT)
    ) u_temp_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .ack      (ack),
        .raw_low  (temp_raw_low_reg),
        .raw_high (temp_raw_high_reg),
        .ref_low  (temp_ref_low_reg),
        .ref_high (temp_ref_high_reg),
        .sample   (raw_temperature),
        .result   (temp_res)
    );

    tpsc_lane #(
        .Y_W  (HREF_W),
        .MULT (HUM_MULT)
    ) u_hum_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .ack      (ack),
        .raw_low  (hum_raw_low_reg),
        .raw_high (hum_raw_high_reg),
        .ref_low  (hum_ref_low_reg),
        .ref_high (hum_ref_high_reg),
        .sample   (raw_humidity),
        .result   (hum_res)
    );

    // compare with the previous values and hold the result item
    tpsc_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .temp_res     (temp_res),
        .hum_res      (hum_res),
        .ack          (ack),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .temperature  (temperature),
        .humidity     (humidity),
        .temp_changed (temp_changed),
        .hum_changed  (hum_changed)
    );

endmodule

// ===== dv/two_point_sensor_calibration_test.sv =====
module two_point_sensor_calibration_test;
    import tpsc_pkg::*;

    // The block takes each accepted complete poll through both lanes and the merge to its result register.
    // Complete polls that give no reading still run the lanes, so give them margin too.
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_IDLE      = 19;
    localparam int PHASES        = 9;
    localparam int POLLS_PER_SET = 178;

    // One poll as the sender sees it, plus the idle cycles drawn before it.
    typedef struct packed {
        logic                    t_rdy;
        logic                    h_rdy;
        logic                    f_ok;
        logic signed [RAW_W-1:0] raw_t;
        logic signed [RAW_W-1:0] raw_h;
        logic [4:0]              gap;
    } poll_t;

    // One calibrated reading as the block should hand it out.
    typedef struct packed {
        logic signed [OUT_W-1:0] temperature;
        logic signed [OUT_W-1:0] humidity;
        logic                    t_chg;
        logic                    h_chg;
    } reading_t;

    // Both calibration lines, held at the register widths.
    typedef struct packed {
        logic signed [RAW_W-1:0] t_x0;
        logic signed [RAW_W-1:0] t_x1;
        logic [TREF_W-1:0]       t_y0;
        logic [TREF_W-1:0]       t_y1;
        logic signed [RAW_W-1:0] h_x0;
        logic signed [RAW_W-1:0] h_x1;
        logic [HREF_W-1:0]       h_y0;
        logic [HREF_W-1:0]       h_y1;
    } calib_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                        in_valid        = 1'b0;
    logic                        in_ready;
    logic                        temp_ready      = 1'b0;
    logic                        hum_ready       = 1'b0;
    logic                        fetch_ok        = 1'b0;
    logic signed [RAW_W-1:0]     raw_temperature = '0;
    logic signed [RAW_W-1:0]     raw_humidity    = '0;

    logic                        out_valid;
    logic                        out_ready       = 1'b0;
    logic signed [OUT_W-1:0]     temperature;
    logic signed [OUT_W-1:0]     humidity;
    logic                        temp_changed;
    logic                        hum_changed;

    logic                        cfg_valid       = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index       = '0;
    logic [CFG_DAT_W-1:0]        cfg_data        = '0;

    two_point_sensor_calibration u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .temp_ready      (temp_ready),
        .hum_ready       (hum_ready),
        .fetch_ok        (fetch_ok),
        .raw_temperature (raw_temperature),
        .raw_humidity    (raw_humidity),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .temperature     (temperature),
        .humidity        (humidity),
        .temp_changed    (temp_changed),
        .hum_changed     (hum_changed),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Polls waiting to be driven, readings still owed by the block.
    poll_t    poll_q[$];
    reading_t pending_readings[$];

    // Shadow of the calibration registers and of the stored previous values.
    calib_t                  cal = '0;
    logic signed [OUT_W-1:0] prev_temp = '0;
    logic signed [OUT_W-1:0] prev_hum  = '0;

    poll_t                   poll_shown;
    logic signed [RAW_W-1:0] last_raw_t = '0;
    logic signed [RAW_W-1:0] last_raw_h = '0;
    bit                      send_quick = 1'b0;
    bit                      take_quick = 1'b0;
    int unsigned             idle_cnt   = 0;
    int unsigned             stall_left = 0;
    int unsigned             err_count  = 0;
    int unsigned             cycle_cnt  = 0;

    // Straight line through (x0,y0),(x1,y1) at sample a, scaled by m, offset by
    // d/2 and then truncated toward zero; the sum wraps to the output width.
    // The raw difference is kept at full width, never wrapped.
    function automatic logic signed [OUT_W-1:0] line_map(input longint x0, input longint x1,
                                                         input longint y0, input longint y1,
                                                         input longint a, input longint m);
        longint d;
        longint num;
        longint sum;
        d = x1 - x0;
        if (d == 0)
            return '0;
        num = (a - x0) * (y1 - y0) * m + d / 2;
        sum = num / d + y0 * m;
        return sum[OUT_W-1:0];
    endfunction

    // Work out what one accepted poll must produce and advance the stored values.
    function automatic void calibrate_poll(input poll_t p);
        logic signed [OUT_W-1:0] t_line;
        logic signed [OUT_W-1:0] t_val;
        logic signed [OUT_W-1:0] h_val;
        reading_t                r;
        // drop polls that are not fully ready or whose fetch failed
        if ({p.h_rdy, p.t_rdy} != READY_MASK || !p.f_ok)
            return;
        t_line = line_map(cal.t_x0, cal.t_x1, cal.t_y0, cal.t_y1, p.raw_t, TEMP_MULT);
        // halve after the wrap, truncating toward zero
        t_val = OUT_W'(t_line / 2);
        h_val = line_map(cal.h_x0, cal.h_x1, cal.h_y0, cal.h_y1, p.raw_h, HUM_MULT);
        r.temperature = t_val;
        r.humidity    = h_val;
        r.t_chg       = (t_val != prev_temp);
        r.h_chg       = (h_val != prev_hum);
        // nothing moved: no reading, stored values stay
        if (!r.t_chg && !r.h_chg)
            return;
        prev_temp = t_val;
        prev_hum  = h_val;
        pending_readings.push_back(r);
    endfunction

    function automatic void check_field(input string what, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // Queue one poll; the idle cycles before it come in stretches, some with none.
    task automatic push_poll(input logic t_rdy, input logic h_rdy, input logic f_ok,
                             input logic signed [RAW_W-1:0] raw_t,
                             input logic signed [RAW_W-1:0] raw_h);
        poll_t p;
        if ($urandom_range(0, 39) == 0)
            send_quick = !send_quick;
        p.t_rdy = t_rdy;
        p.h_rdy = h_rdy;
        p.f_ok  = f_ok;
        p.raw_t = raw_t;
        p.raw_h = raw_h;
        p.gap   = send_quick ? 5'd0 : 5'($urandom_range(0, MAX_IDLE));
        last_raw_t = raw_t;
        last_raw_h = raw_h;
        poll_q.push_back(p);
    endtask

    // Pick a raw sample: repeats, rails, values around the calibration points
    // and plain random words.
    function automatic logic signed [RAW_W-1:0] pick_raw(input logic signed [RAW_W-1:0] prev,
                                                         input logic signed [RAW_W-1:0] x0,
                                                         input logic signed [RAW_W-1:0] x1);
        case ($urandom_range(0, 9))
            0: return prev;
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            2: return RAW_W'(x0 + $urandom_range(0, 8) - 4);
            3: return RAW_W'(x1 + $urandom_range(0, 8) - 4);
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed polls with random samples, the rest random status bits.
    task automatic queue_polls(input int n);
        logic [2:0] status;
        for (int k = 0; k < n; k++)
        begin
            status = ($urandom_range(0, 99) < 80) ? 3'b111 : 3'($urandom);
            push_poll(status[0], status[1], status[2],
                      pick_raw(last_raw_t, cal.t_x0, cal.t_x1),
                      pick_raw(last_raw_h, cal.h_x0, cal.h_x1));
        end
    endtask

    // Write one register and hold until the block takes it; mirror the write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_TEMP_RAW_LOW:  cal.t_x0 = word;
            REG_TEMP_RAW_HIGH: cal.t_x1 = word;
            REG_TEMP_REF_LOW:  cal.t_y0 = word[TREF_W-1:0];
            REG_TEMP_REF_HIGH: cal.t_y1 = word[TREF_W-1:0];
            REG_HUM_RAW_LOW:   cal.h_x0 = word;
            REG_HUM_RAW_HIGH:  cal.h_x1 = word;
            REG_HUM_REF_LOW:   cal.h_y0 = word[HREF_W-1:0];
            REG_HUM_REF_HIGH:  cal.h_y1 = word[HREF_W-1:0];
            default: ;
        endcase
    endtask

    // Load a full calibration set. Unused upper bits of the reference words carry
    // noise, and a few writes to indexes past the register list must change nothing.
    task automatic load_calibration(input calib_t c);
        logic [CFG_DAT_W-1:0] word;
        @(posedge clk);
        for (int i = REG_TEMP_RAW_LOW; i <= REG_HUM_REF_HIGH; i++)
        begin
            word = CFG_DAT_W'($urandom);
            case (cfg_reg_t'(i))
                REG_TEMP_RAW_LOW:  word = c.t_x0;
                REG_TEMP_RAW_HIGH: word = c.t_x1;
                REG_TEMP_REF_LOW:  word[TREF_W-1:0] = c.t_y0;
                REG_TEMP_REF_HIGH: word[TREF_W-1:0] = c.t_y1;
                REG_HUM_RAW_LOW:   word = c.h_x0;
                REG_HUM_RAW_HIGH:  word = c.h_x1;
                REG_HUM_REF_LOW:   word[HREF_W-1:0] = c.h_y0;
                REG_HUM_REF_HIGH:  word[HREF_W-1:0] = c.h_y1;
                default: ;
            endcase
            write_reg(CFG_IDX_W'(i), word);
        end
        repeat ($urandom_range(1, 3))
            write_reg(CFG_IDX_W'($urandom_range(REG_HUM_REF_HIGH + 1, 2**CFG_IDX_W - 1)),
                      CFG_DAT_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Wait until every poll is taken and every reading is in, then let the
    // lanes drain polls that owe nothing. Sample at the falling edge so the
    // queues and valids have settled.
    task automatic wait_quiet();
        do @(negedge clk);
        while (poll_q.size() != 0 || in_valid || pending_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Poll driver: predict on every accepted item, then present the next one once
    // its idle cycles have passed. Valid stays high and the payload stays put
    // until the block takes the item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            idle_cnt <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                calibrate_poll(poll_shown);
            if (!in_valid || in_ready)
            begin
                if (poll_q.size() != 0 && idle_cnt >= poll_q[0].gap)
                begin
                    poll_shown = poll_q.pop_front();
                    in_valid        <= 1'b1;
                    temp_ready      <= poll_shown.t_rdy;
                    hum_ready       <= poll_shown.h_rdy;
                    fetch_ok        <= poll_shown.f_ok;
                    raw_temperature <= poll_shown.raw_t;
                    raw_humidity    <= poll_shown.raw_h;
                    idle_cnt        <= 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (poll_q.size() != 0)
                        idle_cnt <= idle_cnt + 1;
                end
            end
        end
    end

    // Reading monitor: check each accepted reading against the oldest one owed,
    // then stall ready for a drawn number of cycles before taking the next.
    always @(posedge clk or negedge rst_n)
    begin
        reading_t    want;
        int unsigned hold;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_readings.size() == 0)
                begin
                    err_count++;
                    $display("%0t: reading with none expected, expected nothing, %s %0d %0d",
                             $time, "got temperature/humidity", temperature, humidity);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    check_field("temperature", want.temperature, temperature);
                    check_field("humidity", want.humidity, humidity);
                    check_field("temp_changed", want.t_chg, temp_changed);
                    check_field("hum_changed", want.h_chg, hum_changed);
                end
                if ($urandom_range(0, 29) == 0)
                    take_quick = !take_quick;
                hold = take_quick ? 0 : $urandom_range(0, MAX_IDLE);
                stall_left <= hold;
                out_ready  <= (hold == 0);
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= (stall_left == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Give up well past the slowest correct run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        calib_t nc;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Calibration at reset: both raw points equal, so every line is zero and
        // nothing differs from the cleared stored values.
        push_poll(1'b1, 1'b1, 1'b1, 16'sh7FFF, 16'sh8000);
        push_poll(1'b1, 1'b1, 1'b1, 16'sh8000, 16'sh7FFF);
        push_poll(1'b0, 1'b1, 1'b1, 16'sh1234, 16'sh4321);
        push_poll(1'b1, 1'b0, 1'b1, 16'sh1234, 16'sh4321);
        push_poll(1'b1, 1'b1, 1'b0, 16'sh1234, 16'sh4321);
        queue_polls(50);
        wait_quiet();

        for (int ph = 1; ph <= PHASES; ph++)
        begin
            nc.t_x0 = RAW_W'($urandom);
            nc.t_x1 = RAW_W'($urandom);
            nc.t_y0 = TREF_W'($urandom);
            nc.t_y1 = TREF_W'($urandom);
            nc.h_x0 = RAW_W'($urandom);
            nc.h_x1 = RAW_W'($urandom);
            nc.h_y0 = HREF_W'($urandom);
            nc.h_y1 = HREF_W'($urandom);
            case (ph)
                1:
                begin
                    // ordinary rising lines
                    nc = '{t_x0: -16'sd20000, t_x1: 16'sd20000, t_y0: 100, t_y1: 600,
                           h_x0: -16'sd10000, h_x1: 16'sd25000, h_y0: 20, h_y1: 200};
                end
                2:
                begin
                    // widest raw spans, both lines rising, humidity with its points in reverse
                    nc = '{t_x0: 16'sh8000, t_x1: 16'sh7FFF, t_y0: 0, t_y1: 1023,
                           h_x0: 16'sh7FFF, h_x1: 16'sh8000, h_y0: 255, h_y1: 0};
                end
                3:
                begin
                    // steepest slopes: the line value wraps
                    nc = '{t_x0: 16'sd0, t_x1: 16'sd1, t_y0: 0, t_y1: 1023,
                           h_x0: -16'sd1, h_x1: 16'sd0, h_y0: 0, h_y1: 255};
                end
                4:
                begin
                    // flat temperature line, top references
                    nc.t_x1 = nc.t_x0;
                    nc.t_y0 = 1023;
                    nc.h_y1 = 255;
                end
                5:
                begin
                    // flat humidity line
                    nc.h_x1 = nc.h_x0;
                end
                default: ;
            endcase
            load_calibration(nc);

            if (ph == 1)
            begin
                push_poll(1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0);
                // identical poll: no change, no reading
                push_poll(1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0);
                push_poll(1'b1, 1'b1, 1'b1, cal.t_x0, cal.h_x0);
                push_poll(1'b1, 1'b1, 1'b1, cal.t_x1, cal.h_x1);
                push_poll(1'b1, 1'b1, 1'b1, 16'sh8000, 16'sh8000);
                push_poll(1'b1, 1'b1, 1'b1, 16'sh7FFF, 16'sh7FFF);
                // only humidity moves, then only temperature
                push_poll(1'b1, 1'b1, 1'b1, 16'sh7FFF, 16'sd0);
                push_poll(1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0);
                // status not complete or fetch failed: dropped, state kept
                push_poll(1'b0, 1'b0, 1'b0, 16'sh5555, 16'sh2AAA);
                push_poll(1'b0, 1'b1, 1'b1, 16'sh5555, 16'sh2AAA);
                push_poll(1'b1, 1'b0, 1'b1, 16'sh5555, 16'sh2AAA);
                push_poll(1'b1, 1'b1, 1'b0, 16'sh5555, 16'sh2AAA);
                push_poll(1'b1, 1'b1, 1'b1, 16'sd1, -16'sd1);
                push_poll(1'b1, 1'b1, 1'b1, -16'sd1, 16'sd1);
                push_poll(1'b1, 1'b1, 1'b1, 16'sh5555, 16'shAAAA);
                push_poll(1'b1, 1'b1, 1'b1, 16'shAAAA, 16'sh5555);
            end
            queue_polls(POLLS_PER_SET);
            wait_quiet();
        end

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
